// ===== rtl/sbc_pkg.sv =====
// shared types and constants for the sensor boxcar average classifier
package sbc_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int THRESHOLD_W = 16;
   localparam int MARGIN_W    = 8;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_CENTER     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HUMIDITY_MARGIN = CSR_INDEX_W'(1);

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(60);
   localparam logic [MARGIN_W-1:0]    MARGIN_RESET    = MARGIN_W'(2);

   // classification result
   typedef enum logic [1:0] {
      VERDICT_NOT_FILLED  = 2'd0,
      VERDICT_OUT_OF_BAND = 2'd1,
      VERDICT_DROPPING    = 2'd2,
      VERDICT_RISING      = 2'd3
   } verdict_type;

endpackage

// ===== rtl/sbc_channel.sv =====
// one channel: circular sample line and running window sum
module sbc_channel #(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          sample_valid,
   input  logic [sbc_pkg::SAMPLE_W-1:0]  sample,
   output logic [SUM_W-1:0]              sum_next
);
   import sbc_pkg::*;

   logic [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic [SAMPLE_W-1:0] ring_in [WINDOW];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [SAMPLE_W-1:0] oldest;

   // the last tap holds the entry that the current slot overwrites
   assign oldest = ring_ff[WINDOW-1];

   always_comb begin
      ring_in[0] = sample_valid ? sample : oldest;
      for (int i = 1; i < WINDOW; i++) begin
         ring_in[i] = ring_ff[i-1];
      end
      if (sample_valid) begin
         sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
      end else begin
         sum_in = sum_ff;
      end
   end

   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (advance) begin
         sum_ff <= sum_in;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= ring_in[i];
         end
      end
   end

endmodule

// ===== rtl/sbc_average.sv =====
// window sum divided by the window length through a reciprocal multiply
module sbc_average #(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 20
) (
   input  logic [SUM_W-1:0]             sum,
   output logic [sbc_pkg::SAMPLE_W-1:0] average
);
   import sbc_pkg::*;

   // ceil(2^shift / window) is exact for every sum below 2^SUM_W
   localparam int    REC_SHIFT = SUM_W + $clog2(WINDOW);
   localparam int    MULT_W    = SUM_W + 1;
   localparam longint REC_MULT =
      ((longint'(1) << REC_SHIFT) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW);
   localparam logic [MULT_W-1:0] REC_CONST = MULT_W'(REC_MULT);

   logic [SUM_W+MULT_W-1:0] product;

   assign product = (SUM_W+MULT_W)'(sum) * (SUM_W+MULT_W)'(REC_CONST);
   assign average = product[REC_SHIFT +: SAMPLE_W];

endmodule

// ===== rtl/sbc_verdict.sv =====
// humidity band check and temperature trend compare
module sbc_verdict (
   input  logic                            window_filled,
   input  logic [sbc_pkg::SAMPLE_W-1:0]    humidity_average,
   input  logic [sbc_pkg::SAMPLE_W-1:0]    temperature_average,
   input  logic [sbc_pkg::SAMPLE_W-1:0]    temperature_sample,
   input  logic [sbc_pkg::THRESHOLD_W-1:0] band_center,
   input  logic [sbc_pkg::MARGIN_W-1:0]    humidity_margin,
   output sbc_pkg::verdict_type            verdict
);
   import sbc_pkg::*;

   logic [THRESHOLD_W-1:0] band_low;
   logic [THRESHOLD_W:0]   band_high;
   logic                   out_of_band;

   // lower edge clamps at zero, upper edge keeps its carry
   always_comb begin
      if (band_center > THRESHOLD_W'(humidity_margin)) begin
         band_low = band_center - THRESHOLD_W'(humidity_margin);
      end else begin
         band_low = '0;
      end
      band_high   = (THRESHOLD_W+1)'(band_center) + (THRESHOLD_W+1)'(humidity_margin);
      out_of_band = (humidity_average < band_low) ||
                    ((THRESHOLD_W+1)'(humidity_average) > band_high);
      if (!window_filled) begin
         verdict = VERDICT_NOT_FILLED;
      end else if (out_of_band) begin
         verdict = VERDICT_OUT_OF_BAND;
      end else if (temperature_sample < temperature_average) begin
         verdict = VERDICT_DROPPING;
      end else begin
         verdict = VERDICT_RISING;
      end
   end

endmodule

// ===== rtl/sensor_boxcar_average_classifier.sv =====
// top level: three-channel boxcar averager with humidity band and trend verdict
//
// Each accepted transaction carries one CO2 / temperature / humidity sample set
// and a valid flag, and produces exactly one result transaction. A valid set
// replaces the oldest entry of each channel's WINDOW-deep history and updates
// the running sums; an invalid set leaves them alone, but the window position
// still advances. Averages are sum / WINDOW, truncated. Once the position has
// wrapped for the first time the result carries a verdict: humidity out of
// band (threshold +/- margin, both edges inclusive, lower edge clamped at 0),
// else temperature dropping when the raw temperature sample is below its
// average, else rising; before that the verdict reads "not filled".
// Throughput is one transaction per clock unless rsp_stall holds the flow. The
// running sums update at acceptance and stage 1 registers them, the reciprocal
// multiply that divides by WINDOW has stage 2 of its own, and the verdict
// compare feeds the result register. The add/subtract feedback of the running
// sums sets the rate. The sample histories sit in flops cleared by reset, so
// there is no clearing pass after reset.
// Write the configuration only while no transaction is in flight; the band
// registers are read at the verdict stage.
module sensor_boxcar_average_classifier #(
   parameter int WINDOW = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_sample_valid,
   input  logic [sbc_pkg::SAMPLE_W-1:0]      req_co2_sample,
   input  logic [sbc_pkg::SAMPLE_W-1:0]      req_temperature_sample,
   input  logic [sbc_pkg::SAMPLE_W-1:0]      req_humidity_sample,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_verdict,
   output logic [sbc_pkg::SAMPLE_W-1:0]      rsp_co2_average,
   output logic [sbc_pkg::SAMPLE_W-1:0]      rsp_temperature_average,
   output logic [sbc_pkg::SAMPLE_W-1:0]      rsp_humidity_average,
   // configuration write port
   input  logic                              csr_write_enable,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sbc_pkg::*;

   // sum holds up to WINDOW full-scale samples
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW + 1);
   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

   // configuration registers
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [MARGIN_W-1:0]    margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         margin_ff    <= MARGIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BAND_CENTER:     threshold_ff <= csr_write_data[THRESHOLD_W-1:0];
            CSR_HUMIDITY_MARGIN: margin_ff    <= csr_write_data[MARGIN_W-1:0];
            default: ;  // indexes past the register list are dropped
         endcase
      end
   end

   // pipeline flow control: a stage loads when it is empty or drains
   logic out_free;
   logic s2_free;
   logic s1_free;
   logic accept;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // window position and fill flag, advanced on every accepted transaction
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             filled_ff, filled_in;

   always_comb begin
      if (pos_ff == POS_LAST) begin
         pos_in    = '0;
         filled_in = 1'b1;
      end else begin
         pos_in    = pos_ff + POS_W'(1);
         filled_in = filled_ff;
      end
   end

   // per-channel histories and running sums
   logic [SUM_W-1:0] co2_sum_next;
   logic [SUM_W-1:0] temp_sum_next;
   logic [SUM_W-1:0] hum_sum_next;

   sbc_channel #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_co2 (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .sample_valid (req_sample_valid),
      .sample       (req_co2_sample),
      .sum_next     (co2_sum_next)
   );

   sbc_channel #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_temperature (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .sample_valid (req_sample_valid),
      .sample       (req_temperature_sample),
      .sum_next     (temp_sum_next)
   );

   sbc_channel #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_humidity (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .sample_valid (req_sample_valid),
      .sample       (req_humidity_sample),
      .sum_next     (hum_sum_next)
   );

   // stage 1: snapshot of the sums after this transaction
   logic [SUM_W-1:0]    s1_co2_sum_ff;
   logic [SUM_W-1:0]    s1_temp_sum_ff;
   logic [SUM_W-1:0]    s1_hum_sum_ff;
   logic [SAMPLE_W-1:0] s1_temp_sample_ff;
   logic                s1_filled_ff;

   // stage 2: averages out of the reciprocal multiply
   logic [SAMPLE_W-1:0] co2_avg_in, temp_avg_in, hum_avg_in;
   logic [SAMPLE_W-1:0] s2_co2_avg_ff;
   logic [SAMPLE_W-1:0] s2_temp_avg_ff;
   logic [SAMPLE_W-1:0] s2_hum_avg_ff;
   logic [SAMPLE_W-1:0] s2_temp_sample_ff;
   logic                s2_filled_ff;

   sbc_average #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_co2_avg (
      .sum     (s1_co2_sum_ff),
      .average (co2_avg_in)
   );

   sbc_average #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_temp_avg (
      .sum     (s1_temp_sum_ff),
      .average (temp_avg_in)
   );

   sbc_average #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_hum_avg (
      .sum     (s1_hum_sum_ff),
      .average (hum_avg_in)
   );

   // result stage: verdict from the stage 2 averages
   verdict_type         verdict_in;
   verdict_type         rsp_verdict_ff;
   logic [SAMPLE_W-1:0] rsp_co2_avg_ff;
   logic [SAMPLE_W-1:0] rsp_temp_avg_ff;
   logic [SAMPLE_W-1:0] rsp_hum_avg_ff;

   sbc_verdict u_verdict (
      .window_filled       (s2_filled_ff),
      .humidity_average    (s2_hum_avg_ff),
      .temperature_average (s2_temp_avg_ff),
      .temperature_sample  (s2_temp_sample_ff),
      .band_center         (threshold_ff),
      .humidity_margin     (margin_ff),
      .verdict             (verdict_in)
   );

   // valid bits of the three stages
   always_comb begin
      s1_valid_in  = s1_free  ? accept      : s1_valid_ff;
      s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         filled_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pos_ff    <= pos_in;
            filled_ff <= filled_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_co2_sum_ff     <= co2_sum_next;
         s1_temp_sum_ff    <= temp_sum_next;
         s1_hum_sum_ff     <= hum_sum_next;
         s1_temp_sample_ff <= req_temperature_sample;
         s1_filled_ff      <= filled_in;
      end
      if (s2_free && s1_valid_ff) begin
         s2_co2_avg_ff     <= co2_avg_in;
         s2_temp_avg_ff    <= temp_avg_in;
         s2_hum_avg_ff     <= hum_avg_in;
         s2_temp_sample_ff <= s1_temp_sample_ff;
         s2_filled_ff      <= s1_filled_ff;
      end
      if (out_free && s2_valid_ff) begin
         rsp_verdict_ff  <= verdict_in;
         rsp_co2_avg_ff  <= s2_co2_avg_ff;
         rsp_temp_avg_ff <= s2_temp_avg_ff;
         rsp_hum_avg_ff  <= s2_hum_avg_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_verdict             = rsp_verdict_ff;
   assign rsp_co2_average         = rsp_co2_avg_ff;
   assign rsp_temperature_average = rsp_temp_avg_ff;
   assign rsp_humidity_average    = rsp_hum_avg_ff;

`ifndef ASSERT_OFF
   // once the window has wrapped it stays filled
   assert property (@(posedge clock) disable iff (reset) filled_ff |=> filled_ff)
      else $error("window fill flag dropped");

   // position never leaves the window
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_LAST)
      else $error("window position out of range");

   // an accepted transaction always lands in stage 1
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction lost at stage 1");

   // no verdict can be reported while the window has never wrapped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !filled_ff) |-> (rsp_verdict_ff == VERDICT_NOT_FILLED))
      else $error("verdict given before window filled");
`endif

endmodule

// ===== bench/tb_sensor_boxcar_average_classifier.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sensor boxcar average classifier
module tb_sensor_boxcar_average_classifier;
   import sbc_pkg::*;

   localparam int BOXCAR_DEPTH = 10;
   // watchdog limit, with plenty of room for the slowest correct run
   localparam int CYCLE_LIMIT  = 500000;
   // config indexes the block must ignore
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HIGH = '1;

   // one sample set as carried by a request transaction
   typedef struct {
      bit                  valid;
      logic [SAMPLE_W-1:0] co2;
      logic [SAMPLE_W-1:0] temp;
      logic [SAMPLE_W-1:0] hum;
   } sample_set_type;

   // one response transaction
   typedef struct {
      verdict_type         verdict;
      logic [SAMPLE_W-1:0] co2;
      logic [SAMPLE_W-1:0] temp;
      logic [SAMPLE_W-1:0] hum;
   } boxcar_result_type;

   // dut connections, all inputs known from time zero
   logic                   clock                  = 1'b0;
   logic                   reset                  = 1'b1;
   logic                   req_valid              = 1'b0;
   logic                   req_stall;
   logic                   req_sample_valid       = 1'b0;
   logic [SAMPLE_W-1:0]    req_co2_sample         = '0;
   logic [SAMPLE_W-1:0]    req_temperature_sample = '0;
   logic [SAMPLE_W-1:0]    req_humidity_sample    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall              = 1'b0;
   logic [1:0]             rsp_verdict;
   logic [SAMPLE_W-1:0]    rsp_co2_average;
   logic [SAMPLE_W-1:0]    rsp_temperature_average;
   logic [SAMPLE_W-1:0]    rsp_humidity_average;
   logic                   csr_write_enable       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index              = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data         = '0;

   // predictor state: sample histories, running sums, held averages, band setup
   logic [SAMPLE_W-1:0]    co2_hist[BOXCAR_DEPTH]  = '{default: '0};
   logic [SAMPLE_W-1:0]    temp_hist[BOXCAR_DEPTH] = '{default: '0};
   logic [SAMPLE_W-1:0]    hum_hist[BOXCAR_DEPTH]  = '{default: '0};
   logic [19:0]            co2_total               = '0;
   logic [19:0]            temp_total              = '0;
   logic [19:0]            hum_total               = '0;
   int                     next_slot               = 0;
   bit                     window_full             = 1'b0;
   logic [SAMPLE_W-1:0]    co2_mean                = '0;
   logic [SAMPLE_W-1:0]    temp_mean               = '0;
   logic [SAMPLE_W-1:0]    hum_mean                = '0;
   logic [THRESHOLD_W-1:0] band_center             = THRESHOLD_RESET;
   logic [MARGIN_W-1:0]    band_half_width         = MARGIN_RESET;

   // averages and verdicts still owed by the dut, oldest first
   boxcar_result_type      awaited_averages[$];
   int                     mismatch_count          = 0;
   int                     cycle_count             = 0;
   // random idle bursts on both channels, switched off for the last stretch
   bit                     idle_bursts             = 1'b1;

   sensor_boxcar_average_classifier #(
      .WINDOW(BOXCAR_DEPTH)
   ) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sample_valid       (req_sample_valid),
      .req_co2_sample         (req_co2_sample),
      .req_temperature_sample (req_temperature_sample),
      .req_humidity_sample    (req_humidity_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_verdict            (rsp_verdict),
      .rsp_co2_average        (rsp_co2_average),
      .rsp_temperature_average(rsp_temperature_average),
      .rsp_humidity_average   (rsp_humidity_average),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // swap the oldest history entry for the fresh sample and return the new mean
   function automatic logic [SAMPLE_W-1:0] slide_window(ref logic [SAMPLE_W-1:0]
                                                           hist[BOXCAR_DEPTH],
                                                        ref logic [19:0] total,
                                                        input int pos,
                                                        input logic [SAMPLE_W-1:0] fresh);
      // the sum always holds the old entry, so the subtract cannot underflow
      total     = total - hist[pos] + fresh;
      hist[pos] = fresh;
      return SAMPLE_W'(total / BOXCAR_DEPTH);
   endfunction

   // advance the predictor by one sample set and return the response it owes
   function automatic boxcar_result_type classify_sample_set(input sample_set_type s);
      boxcar_result_type r;
      int                lo_edge;
      int                hi_edge;
      // invalid sets leave histories, sums and held averages alone
      if (s.valid) begin
         co2_mean  = slide_window(co2_hist, co2_total, next_slot, s.co2);
         temp_mean = slide_window(temp_hist, temp_total, next_slot, s.temp);
         hum_mean  = slide_window(hum_hist, hum_total, next_slot, s.hum);
      end
      // the position moves on every set, valid or not
      next_slot++;
      if (next_slot >= BOXCAR_DEPTH) begin
         next_slot   = 0;
         window_full = 1'b1;
      end
      r.verdict = VERDICT_NOT_FILLED;
      if (window_full) begin
         // lower edge clamps at zero, upper edge is not allowed to wrap
         lo_edge = (band_center > band_half_width) ?
                   int'(band_center) - int'(band_half_width) : 0;
         hi_edge = int'(band_center) + int'(band_half_width);
         if (int'(hum_mean) < lo_edge || int'(hum_mean) > hi_edge) begin
            r.verdict = VERDICT_OUT_OF_BAND;
         end else if (s.temp < temp_mean) begin
            // raw sample against held average, even on an invalid set
            r.verdict = VERDICT_DROPPING;
         end else begin
            r.verdict = VERDICT_RISING;
         end
      end
      r.co2  = co2_mean;
      r.temp = temp_mean;
      r.hum  = hum_mean;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 65535) begin
         return '1;
      end
      return SAMPLE_W'(v);
   endfunction

   // mostly clustered around the phase levels so verdicts mix, some fully random
   function automatic sample_set_type random_sample_set(input int hum_level,
                                                        input int temp_level);
      sample_set_type s;
      s.valid = ($urandom_range(0, 99) < 85);
      s.co2   = SAMPLE_W'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         s.temp = SAMPLE_W'($urandom);
         s.hum  = SAMPLE_W'($urandom);
      end else begin
         s.temp = clamp_sample(temp_level + int'($urandom_range(0, 400)) - 200);
         s.hum  = clamp_sample(hum_level + int'($urandom_range(0, 80)) - 40);
      end
      return s;
   endfunction

   // humidity level for a random phase, biased toward both ends of the range
   function automatic int pick_level();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, 1) ? int'($urandom_range(0, 300)) :
                                       int'($urandom_range(65235, 65535));
      end
      return int'($urandom_range(0, 65535));
   endfunction

   // ---------------------------------------------------------------------------
   // shared driving and checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // drive one request transaction and hold it until the dut takes it
   task automatic send_sample_set(input sample_set_type s);
      // optional gap before the transaction; valid drops at the previous accept
      if (idle_bursts && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_sample_valid       <= s.valid;
      req_co2_sample         <= s.co2;
      req_temperature_sample <= s.temp;
      req_humidity_sample    <= s.hum;
      awaited_averages.push_back(classify_sample_set(s));
      // values read right after the edge are the ones the edge sampled
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
   endtask

   task automatic send_fields(input bit valid, input logic [SAMPLE_W-1:0] co2,
                              input logic [SAMPLE_W-1:0] temp,
                              input logic [SAMPLE_W-1:0] hum);
      sample_set_type s;
      s.valid = valid;
      s.co2   = co2;
      s.temp  = temp;
      s.hum   = hum;
      send_sample_set(s);
   endtask

   // stop sending and wait for every owed response, plus the pipeline depth
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_averages.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // bits above a register's width are dropped, unknown indexes ignored
      if (index == CSR_BAND_CENTER) begin
         band_center = data[THRESHOLD_W-1:0];
      end else if (index == CSR_HUMIDITY_MARGIN) begin
         band_half_width = data[MARGIN_W-1:0];
      end
   endtask

   // retune the humidity band once the block has gone quiet
   task automatic program_band(input int center, input logic [CSR_DATA_W-1:0] margin_word);
      drain_results();
      write_csr(CSR_BAND_CENTER, CSR_DATA_W'(center));
      write_csr(CSR_HUMIDITY_MARGIN, margin_word);
   endtask

   // response side: random stall bursts with quiet stretches in between
   initial begin
      forever begin
         @(posedge clock);
         if (idle_bursts && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every accepted response is matched against the oldest owed one
   always @(posedge clock) begin : check_responses
      boxcar_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_averages.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = awaited_averages.pop_front();
            if (rsp_verdict !== want.verdict) begin
               report_mismatch($sformatf("verdict %0d, expected %0d",
                                         rsp_verdict, want.verdict));
            end
            if (rsp_co2_average !== want.co2) begin
               report_mismatch($sformatf("co2 average %0d, expected %0d",
                                         rsp_co2_average, want.co2));
            end
            if (rsp_temperature_average !== want.temp) begin
               report_mismatch($sformatf("temperature average %0d, expected %0d",
                                         rsp_temperature_average, want.temp));
            end
            if (rsp_humidity_average !== want.hum) begin
               report_mismatch($sformatf("humidity average %0d, expected %0d",
                                         rsp_humidity_average, want.hum));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // first pass around the window under the reset band setup
   task automatic test_window_fill();
      int i;
      // invalid set while nothing is filled: position moves, averages stay zero
      send_fields(1'b0, '1, '1, '0);
      // co2 and temperature swing between the extremes, humidity sits at the top;
      // the wrap lands on the ninth valid set, the tenth replaces the skipped slot
      for (i = 0; i < BOXCAR_DEPTH; i++) begin
         send_fields(1'b1, i[0] ? '1 : '0, i[0] ? '1 : SAMPLE_W'(i * 1000 + 1), '1);
      end
   endtask

   // band edges with the humidity average pinned at full scale
   task automatic test_band_edges_high();
      // upper edge is inclusive; the upper margin bits of the write are dropped;
      // temperature equal to its average counts as rising
      program_band(int'(hum_mean) - 2, 16'hAB02);
      send_fields(1'b0, SAMPLE_W'($urandom), temp_mean, SAMPLE_W'($urandom));
      // one above the upper edge
      program_band(int'(hum_mean) - 3, 16'h0002);
      send_fields(1'b0, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      // zero margin, band is a single value; writes to unknown indexes do nothing
      program_band(int'(hum_mean), 16'h0000);
      write_csr(CSR_UNMAPPED_LOW, '1);
      write_csr(CSR_UNMAPPED_HIGH, 16'h5A5A);
      send_fields(1'b0, '0, temp_mean - 1'b1, '0);
      // threshold plus margin past 16 bits must not wrap
      program_band(65535, 16'h00FF);
      send_fields(1'b0, '1, '0, '1);
   endtask

   // bring humidity down to zero under a band whose lower edge clamps
   task automatic test_low_band_saturation();
      int i;
      program_band(1, 16'h00FF);
      for (i = 0; i < BOXCAR_DEPTH; i++) begin
         send_fields(1'b1, i[0] ? '0 : '1, i[1] ? '1 : '0, '0);
      end
      // average zero sits one below the lower edge
      program_band(1, 16'h0000);
      send_fields(1'b0, SAMPLE_W'($urandom), '1, SAMPLE_W'($urandom));
      // lower edge at zero, inclusive
      program_band(0, 16'h0000);
      send_fields(1'b0, SAMPLE_W'($urandom), '1, SAMPLE_W'($urandom));
   endtask

   // random sample sets in phases, each under its own band setup
   task automatic test_random_traffic();
      int phase;
      int n;
      int hum_level;
      int temp_level;
      int center;
      int half;
      for (phase = 0; phase < 15; phase++) begin
         hum_level  = (phase == 0) ? int'($urandom_range(0, 30)) :
                      (phase == 1) ? int'($urandom_range(65400, 65535)) : pick_level();
         temp_level = int'($urandom_range(0, 65535));
         case (phase)
            0: begin
               center = 0;
               half   = 0;
            end
            1: begin
               center = 65535;
               half   = 255;
            end
            2: begin
               center = hum_level;
               half   = 0;
            end
            3: begin
               center = hum_level;
               half   = 255;
            end
            default: begin
               center = clamp_sample(hum_level + int'($urandom_range(0, 600)) - 300);
               half   = int'($urandom_range(0, 255));
            end
         endcase
         // junk in the upper margin bits checks the register width
         program_band(center, {8'($urandom), 8'(half)});
         if ($urandom_range(0, 3) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_LOW : CSR_UNMAPPED_HIGH,
                      CSR_DATA_W'($urandom));
         end
         for (n = 0; n < 100; n++) begin
            send_sample_set(random_sample_set(hum_level, temp_level));
         end
      end
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_steady_stream();
      int n;
      int hum_level;
      hum_level   = int'(band_center);
      idle_bursts = 1'b0;
      for (n = 0; n < 100; n++) begin
         send_sample_set(random_sample_set(hum_level, int'(temp_mean)));
      end
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_window_fill();
      test_band_edges_high();
      test_low_band_saturation();
      test_random_traffic();
      test_steady_stream();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
